// ----- hdl/fst_pkg.sv -----
// ----------------------------------------------------------------------------
// fst_pkg
// This package holds the types, constants and triangle table that the segment
// tessellator modules share.
// ----------------------------------------------------------------------------
package fst_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HW_W = 31;
  localparam logic [HW_W-1:0] HALF_WIDTH_RESET = HW_W'(64'd1 << FRAC_BITS);

  localparam int UNIT_SHIFT = 30;
  localparam int STEPS_PER_STAGE = 2;
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_STAGES = (SQRT_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DIV_STEPS = 31;
  localparam int DIV_STAGES = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int NUM_TRI = 6;
  localparam int NUM_CORNERS = 8;

  typedef logic [2:0] corner_idx_t;
  typedef logic [2:0] tri_idx_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] radius;
    logic [31:0]        outline_color;
    logic [31:0]        body_color;
  } fst_in_t;

  typedef struct packed {
    logic signed [31:0] corner0_x;
    logic signed [31:0] corner0_y;
    logic signed [31:0] corner1_x;
    logic signed [31:0] corner1_y;
    logic signed [31:0] corner2_x;
    logic signed [31:0] corner2_y;
    logic [31:0]        tri_color;
    logic               last_tri;
  } fst_out_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [31:0]        r;
    logic [31:0]        color;
    logic               dx_neg;
    logic               dy_neg;
    logic               degen;
  } fst_side_t;

  typedef struct packed {
    fst_side_t   side;
    logic [30:0] ex;
    logic [30:0] ey;
  } fst_sqtag_t;

  typedef struct packed {
    fst_side_t   side;
    logic [30:0] ux;
    logic [30:0] uy;
  } fst_item_t;

  typedef struct packed {
    corner_idx_t c0;
    corner_idx_t c1;
    corner_idx_t c2;
  } fst_tri_t;

  function automatic fst_tri_t tri_corners(input tri_idx_t k);
    fst_tri_t t;
    unique case (k)
      3'd0: t = '{3'd0, 3'd1, 3'd2};
      3'd1: t = '{3'd3, 3'd1, 3'd2};
      3'd2: t = '{3'd3, 3'd4, 3'd2};
      3'd3: t = '{3'd3, 3'd4, 3'd5};
      3'd4: t = '{3'd6, 3'd4, 3'd5};
      3'd5: t = '{3'd6, 3'd7, 3'd5};
      default: t = '{3'd0, 3'd0, 3'd0};
    endcase
    return t;
  endfunction

endpackage

// ----- hdl/fst_front.sv -----
// ----------------------------------------------------------------------------
// fst_front
// Accepts segment beats against queue credits, classifies them, normalizes
// the direction vector and forms the squared length.
// ----------------------------------------------------------------------------
module fst_front import fst_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [HW_W-1:0]  cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  fst_in_t          in_data,
  input  logic             credit_return,
  output logic             sq_valid,
  output logic [63:0]      sq_sum,
  output fst_sqtag_t       sq_tag
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [HW_W-1:0] half_width_r;
  logic [CW-1:0]   credit_r;
  logic            accept;

  logic [5:0]      v_r;
  fst_side_t       side0_r, side1_r, side2_r, side3_r, side4_r, side5_r;
  logic [31:0]     ex0_r, ey0_r;
  logic [30:0]     ex1_r, ey1_r, m1_r, ex2_r, ey2_r, m2_r, ex3_r, ey3_r;
  logic [61:0]     sqx4_r, sqy4_r;
  logic [30:0]     ex4_r, ey4_r, ex5_r, ey5_r;
  logic [63:0]     sum5_r;

  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  fst_side_t          side_in;
  logic [30:0]        ex1_nxt, ey1_nxt, m1_nxt, ex2_nxt, ey2_nxt, m2_nxt;
  logic [30:0]        ex3_nxt, ey3_nxt, m3_nxt;

  assign in_ready = credit_r < CW'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    dx  = $signed({in_data.end_x[31], in_data.end_x}) -
          $signed({in_data.start_x[31], in_data.start_x});
    dy  = $signed({in_data.end_y[31], in_data.end_y}) -
          $signed({in_data.start_y[31], in_data.start_y});
    adx = dx[32] ? 33'(-dx) : 33'(dx);
    ady = dy[32] ? 33'(-dy) : 33'(dy);
    side_in.start_x = in_data.start_x;
    side_in.start_y = in_data.start_y;
    side_in.end_x   = in_data.end_x;
    side_in.end_y   = in_data.end_y;
    side_in.dx_neg  = dx[32];
    side_in.dy_neg  = dy[32];
    side_in.degen   = (dx == '0) && (dy == '0);
    if (in_data.radius[31] || (in_data.radius == '0)) begin
      side_in.r     = {1'b0, half_width_r};
      side_in.color = in_data.outline_color;
    end else begin
      side_in.r     = 32'(in_data.radius) + {1'b0, half_width_r};
      side_in.color = in_data.body_color;
    end
  end

  always_comb begin
    logic [31:0] m0;
    m0 = (ex0_r > ey0_r) ? ex0_r : ey0_r;
    if (m0[31]) begin
      ex1_nxt = ex0_r[31:1];
      ey1_nxt = ey0_r[31:1];
      m1_nxt  = m0[31:1];
    end else begin
      ex1_nxt = ex0_r[30:0];
      ey1_nxt = ey0_r[30:0];
      m1_nxt  = m0[30:0];
    end
    if (m1_nxt[30:15] == '0) begin
      ex1_nxt = ex1_nxt << 16;
      ey1_nxt = ey1_nxt << 16;
      m1_nxt  = m1_nxt << 16;
    end
  end

  always_comb begin
    ex2_nxt = ex1_r;
    ey2_nxt = ey1_r;
    m2_nxt  = m1_r;
    if (m2_nxt[30:23] == '0) begin
      ex2_nxt = ex2_nxt << 8;
      ey2_nxt = ey2_nxt << 8;
      m2_nxt  = m2_nxt << 8;
    end
    if (m2_nxt[30:27] == '0) begin
      ex2_nxt = ex2_nxt << 4;
      ey2_nxt = ey2_nxt << 4;
      m2_nxt  = m2_nxt << 4;
    end
  end

  always_comb begin
    ex3_nxt = ex2_r;
    ey3_nxt = ey2_r;
    m3_nxt  = m2_r;
    if (m3_nxt[30:29] == '0) begin
      ex3_nxt = ex3_nxt << 2;
      ey3_nxt = ey3_nxt << 2;
      m3_nxt  = m3_nxt << 2;
    end
    if (!m3_nxt[30]) begin
      ex3_nxt = ex3_nxt << 1;
      ey3_nxt = ey3_nxt << 1;
      m3_nxt  = m3_nxt << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_WIDTH_RESET;
      credit_r     <= '0;
      v_r          <= '0;
    end else begin
      if (cfg_we) begin
        half_width_r <= cfg_wdata;
      end
      unique case ({accept, credit_return})
        2'b10:   credit_r <= credit_r + CW'(1);
        2'b01:   credit_r <= credit_r - CW'(1);
        default: credit_r <= credit_r;
      endcase
      v_r <= {v_r[4:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    side0_r <= side_in;
    ex0_r   <= adx[31:0];
    ey0_r   <= ady[31:0];
    side1_r <= side0_r;
    ex1_r   <= ex1_nxt;
    ey1_r   <= ey1_nxt;
    m1_r    <= m1_nxt;
    side2_r <= side1_r;
    ex2_r   <= ex2_nxt;
    ey2_r   <= ey2_nxt;
    m2_r    <= m2_nxt;
    side3_r <= side2_r;
    ex3_r   <= ex3_nxt;
    ey3_r   <= ey3_nxt;
    side4_r <= side3_r;
    ex4_r   <= ex3_r;
    ey4_r   <= ey3_r;
    sqx4_r  <= ex3_r * ex3_r;
    sqy4_r  <= ey3_r * ey3_r;
    side5_r <= side4_r;
    ex5_r   <= ex4_r;
    ey5_r   <= ey4_r;
    sum5_r  <= 64'(sqx4_r) + 64'(sqy4_r);
  end

  assign sq_valid     = v_r[5];
  assign sq_sum       = sum5_r;
  assign sq_tag.side  = side5_r;
  assign sq_tag.ex    = ex5_r;
  assign sq_tag.ey    = ey5_r;

endmodule

// ----- hdl/fst_sqrt.sv -----
// ----------------------------------------------------------------------------
// fst_sqrt
// Pipelined integer square root, two result bits per stage, with the
// segment's side data carried alongside.
// ----------------------------------------------------------------------------
module fst_sqrt import fst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [63:0] in_sum,
  input  fst_sqtag_t  in_tag,
  output logic        out_valid,
  output logic [31:0] out_root,
  output fst_sqtag_t  out_tag
);

  logic [SQRT_STAGES:0] v_r;
  logic [63:0]          s_r    [SQRT_STAGES+1];
  logic [31:0]          root_r [SQRT_STAGES+1];
  logic [33:0]          rem_r  [SQRT_STAGES+1];
  fst_sqtag_t           tag_r  [SQRT_STAGES+1];

  assign v_r[0]    = in_valid;
  assign s_r[0]    = in_sum;
  assign root_r[0] = '0;
  assign rem_r[0]  = '0;
  assign tag_r[0]  = in_tag;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [63:0] s_nxt;
    logic [31:0] root_nxt;
    logic [33:0] rem_nxt;

    always_comb begin
      logic [35:0] cand;
      logic [35:0] trial;
      s_nxt    = s_r[g];
      root_nxt = root_r[g];
      rem_nxt  = rem_r[g];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (g * STEPS_PER_STAGE + j < SQRT_STEPS) begin
          cand  = {rem_nxt, s_nxt[63:62]};
          trial = {2'b00, root_nxt, 2'b01};
          if (cand >= trial) begin
            rem_nxt  = 34'(cand - trial);
            root_nxt = {root_nxt[30:0], 1'b1};
          end else begin
            rem_nxt  = cand[33:0];
            root_nxt = {root_nxt[30:0], 1'b0};
          end
          s_nxt = {s_nxt[61:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      s_r[g+1]    <= s_nxt;
      root_r[g+1] <= root_nxt;
      rem_r[g+1]  <= rem_nxt;
      tag_r[g+1]  <= tag_r[g];
    end
  end

  assign out_valid = v_r[SQRT_STAGES];
  assign out_root  = root_r[SQRT_STAGES];
  assign out_tag   = tag_r[SQRT_STAGES];

endmodule

// ----- hdl/fst_div.sv -----
// ----------------------------------------------------------------------------
// fst_div
// Pipelined restoring divider that forms both unit direction components in
// unsigned Q1.30, two quotient bits per stage (one in the final stage).
// ----------------------------------------------------------------------------
module fst_div import fst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_len,
  input  fst_sqtag_t  in_tag,
  output logic        out_valid,
  output fst_item_t   out_item
);

  logic [DIV_STAGES:0] v_r;
  logic [31:0]         len_r  [DIV_STAGES+1];
  logic [32:0]         remx_r [DIV_STAGES+1];
  logic [32:0]         remy_r [DIV_STAGES+1];
  logic [30:0]         qx_r   [DIV_STAGES+1];
  logic [30:0]         qy_r   [DIV_STAGES+1];
  fst_side_t           side_r [DIV_STAGES+1];

  function automatic logic [63:0] div_step(input logic [32:0] rem, input logic [30:0] q,
                                           input logic [31:0] len);
    logic [32:0] r;
    logic [30:0] qq;
    if (rem >= {1'b0, len}) begin
      r  = rem - {1'b0, len};
      qq = {q[29:0], 1'b1};
    end else begin
      r  = rem;
      qq = {q[29:0], 1'b0};
    end
    return {r[31:0], 1'b0, qq};
  endfunction

  assign v_r[0]    = in_valid;
  assign len_r[0]  = in_len;
  assign remx_r[0] = {2'b00, in_tag.ex};
  assign remy_r[0] = {2'b00, in_tag.ey};
  assign qx_r[0]   = '0;
  assign qy_r[0]   = '0;
  assign side_r[0] = in_tag.side;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [32:0] remx_nxt, remy_nxt;
    logic [30:0] qx_nxt, qy_nxt;

    always_comb begin
      logic [63:0] sx;
      logic [63:0] sy;
      remx_nxt = remx_r[g];
      remy_nxt = remy_r[g];
      qx_nxt   = qx_r[g];
      qy_nxt   = qy_r[g];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (g * STEPS_PER_STAGE + j < DIV_STEPS) begin
          sx       = div_step(remx_nxt, qx_nxt, len_r[g]);
          sy       = div_step(remy_nxt, qy_nxt, len_r[g]);
          remx_nxt = sx[63:31];
          qx_nxt   = sx[30:0];
          remy_nxt = sy[63:31];
          qy_nxt   = sy[30:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      len_r[g+1]  <= len_r[g];
      remx_r[g+1] <= remx_nxt;
      remy_r[g+1] <= remy_nxt;
      qx_r[g+1]   <= qx_nxt;
      qy_r[g+1]   <= qy_nxt;
      side_r[g+1] <= side_r[g];
    end
  end

  assign out_valid     = v_r[DIV_STAGES];
  assign out_item.side = side_r[DIV_STAGES];
  assign out_item.ux   = qx_r[DIV_STAGES];
  assign out_item.uy   = qy_r[DIV_STAGES];

endmodule

// ----- hdl/fst_queue.sv -----
// ----------------------------------------------------------------------------
// fst_queue
// Small FIFO of classified segments between the front pipeline and the
// triangle emitter.
// ----------------------------------------------------------------------------
module fst_queue import fst_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  fst_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output fst_item_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fst_item_t   entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign pop_valid = count_r != '0;
  assign pop_item  = entry_r[rd_ptr_r];
  assign do_pop    = pop_valid && pop_ready;
  assign do_push   = push && (count_r != CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- hdl/fst_back.sv -----
// ----------------------------------------------------------------------------
// fst_back
// Scales the unit direction by the radius, builds the eight saturated
// corners and emits the six triangles of a segment, one per beat.
// ----------------------------------------------------------------------------
module fst_back import fst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fst_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output fst_out_t  out_data
);

  localparam logic signed [35:0] SAT_MAX = 36'sh07FFFFFFF;
  localparam logic signed [35:0] SAT_MIN = -36'sh080000000;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    if (v > SAT_MAX) begin
      return 32'h7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  logic        vm_r, vn_r, vc_r, ev_r;
  fst_side_t   sm_r, sn_r;
  logic [62:0] prodx_r, prody_r;
  logic signed [33:0] nx_r, ny_r, tx_r, ty_r;
  logic [31:0] cx_r [NUM_CORNERS];
  logic [31:0] cy_r [NUM_CORNERS];
  logic [31:0] color_c_r;
  logic [31:0] ox_r [NUM_CORNERS];
  logic [31:0] oy_r [NUM_CORNERS];
  logic [31:0] color_o_r;
  tri_idx_t    cnt_r;

  logic        last, em_take, c_free, n_free, m_free;
  logic [32:0] px, py;
  logic signed [35:0] vx [NUM_CORNERS];
  logic signed [35:0] vy [NUM_CORNERS];
  fst_tri_t    sel;

  assign last    = cnt_r == tri_idx_t'(NUM_TRI - 1);
  assign em_take = !ev_r || (out_ready && last);
  assign c_free  = !vc_r || em_take;
  assign n_free  = !vn_r || c_free;
  assign m_free  = !vm_r || n_free;
  assign in_ready = m_free;

  always_comb begin
    logic [62:0] rx, ry;
    rx = prodx_r + (63'd1 << (UNIT_SHIFT - 1));
    ry = prody_r + (63'd1 << (UNIT_SHIFT - 1));
    px = sm_r.degen ? '0 : rx[62:UNIT_SHIFT];
    py = sm_r.degen ? '0 : ry[62:UNIT_SHIFT];
  end

  always_comb begin
    logic signed [35:0] ax, ay, bx, by, nx, ny, tx, ty;
    ax = 36'(sn_r.start_x);
    ay = 36'(sn_r.start_y);
    bx = 36'(sn_r.end_x);
    by = 36'(sn_r.end_y);
    nx = 36'(nx_r);
    ny = 36'(ny_r);
    tx = 36'(tx_r);
    ty = 36'(ty_r);
    vx[0] = bx - nx - tx;  vy[0] = by - ny - ty;
    vx[1] = bx + nx - tx;  vy[1] = by + ny - ty;
    vx[2] = bx - nx;       vy[2] = by - ny;
    vx[3] = bx + nx;       vy[3] = by + ny;
    vx[4] = ax - nx;       vy[4] = ay - ny;
    vx[5] = ax + nx;       vy[5] = ay + ny;
    vx[6] = ax - nx + tx;  vy[6] = ay - ny + ty;
    vx[7] = ax + nx + tx;  vy[7] = ay + ny + ty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r  <= 1'b0;
      vn_r  <= 1'b0;
      vc_r  <= 1'b0;
      ev_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (m_free) begin
        vm_r <= in_valid;
      end
      if (n_free) begin
        vn_r <= vm_r;
      end
      if (c_free) begin
        vc_r <= vn_r;
      end
      if (em_take) begin
        ev_r  <= vc_r;
        cnt_r <= '0;
      end else if (out_ready) begin
        cnt_r <= cnt_r + tri_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_free) begin
      sm_r    <= in_item.side;
      prodx_r <= in_item.ux * in_item.side.r;
      prody_r <= in_item.uy * in_item.side.r;
    end
    if (n_free) begin
      sn_r <= sm_r;
      nx_r <= sm_r.dy_neg ? -$signed({1'b0, py}) : $signed({1'b0, py});
      ny_r <= sm_r.dx_neg ? $signed({1'b0, px}) : -$signed({1'b0, px});
      tx_r <= sm_r.dx_neg ? $signed({1'b0, px}) : -$signed({1'b0, px});
      ty_r <= sm_r.dy_neg ? $signed({1'b0, py}) : -$signed({1'b0, py});
    end
    if (c_free) begin
      color_c_r <= sn_r.color;
      for (int i = 0; i < NUM_CORNERS; i++) begin
        cx_r[i] <= sat32(vx[i]);
        cy_r[i] <= sat32(vy[i]);
      end
    end
    if (em_take) begin
      color_o_r <= color_c_r;
      for (int i = 0; i < NUM_CORNERS; i++) begin
        ox_r[i] <= cx_r[i];
        oy_r[i] <= cy_r[i];
      end
    end
  end

  assign sel = tri_corners(cnt_r);

  assign out_valid          = ev_r;
  assign out_data.corner0_x = ox_r[sel.c0];
  assign out_data.corner0_y = oy_r[sel.c0];
  assign out_data.corner1_x = ox_r[sel.c1];
  assign out_data.corner1_y = oy_r[sel.c1];
  assign out_data.corner2_x = ox_r[sel.c2];
  assign out_data.corner2_y = oy_r[sel.c2];
  assign out_data.tri_color = color_o_r;
  assign out_data.last_tri  = last;

endmodule

// ----- hdl/fat_segment_tessellator.sv -----
// ----------------------------------------------------------------------------
// fat_segment_tessellator
// Turns one thick line segment into six triangles with square end caps.
//
//   Port group   Direction  Handshake        Beat
//   in_*         input      valid / ready    one segment (fst_in_t)
//   out_*        output     valid / ready    one triangle (fst_out_t)
//   cfg_*        input      write enable     half width, Q15.16
//
// Each segment produces six output beats, one per cycle while out_ready is
// high; the triangle emitter sets the sustained segment rate.
// The first triangle appears after its segment has passed the normalize,
// square root and divide pipelines, the queue and the back end stages.
// Reset is synchronous and clears control state; the half width returns to
// one unit. Input takes beats, independent of output stalls, while fewer
// than QUEUE_DEPTH segments sit between the input and the queue's output.
// ----------------------------------------------------------------------------
module fat_segment_tessellator import fst_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [HW_W-1:0] cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  fst_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fst_out_t        out_data
);

  logic       sq_valid, rt_valid, dv_valid, q_valid, bk_ready;
  logic [63:0] sq_sum;
  logic [31:0] rt_root;
  fst_sqtag_t sq_tag, rt_tag;
  fst_item_t  dv_item, q_item;

  fst_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .credit_return (q_valid && bk_ready),
    .sq_valid      (sq_valid),
    .sq_sum        (sq_sum),
    .sq_tag        (sq_tag)
  );

  fst_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_sum    (sq_sum),
    .in_tag    (sq_tag),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_tag   (rt_tag)
  );

  fst_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rt_valid),
    .in_len    (rt_root),
    .in_tag    (rt_tag),
    .out_valid (dv_valid),
    .out_item  (dv_item)
  );

  fst_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (dv_valid),
    .push_item (dv_item),
    .pop_valid (q_valid),
    .pop_ready (bk_ready),
    .pop_item  (q_item)
  );

  fst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (bk_ready),
    .in_item   (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
